/* design/udpq_pkg.sv */
// Shared types, codes and helpers for the UDP port demultiplexer.
// No dependencies; imported by every module of the block.
package udpq_pkg;

  localparam int DEF_PORT_SLOTS  = 32;
  localparam int DEF_QUEUE_DEPTH = 16;

  localparam logic [15:0] MIN_FRAME_LEN = 16'd42;
  localparam logic [7:0]  VER_IHL_IPV4  = 8'h45;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [15:0] MIN_IP_LEN    = 16'd28;
  localparam logic [16:0] ETH_HDR_LEN   = 17'd14;
  localparam logic [16:0] IP_HDR_LEN    = 17'd20;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;

  typedef enum logic [1:0] {
    MODE_BIND   = 2'd0,
    MODE_UNBIND = 2'd1,
    MODE_PKT    = 2'd2,
    MODE_RECV   = 2'd3
  } mode_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_REJECT  = 3'd1;
  localparam logic [2:0] ST_DROP    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_RELEASE = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] port;
    logic [15:0] buffer_handle;
    logic [15:0] frame_len;
    logic [7:0]  ver_ihl;
    logic [7:0]  protocol;
    logic [31:0] dest_ip;
    logic [15:0] ip_total_len;
    logic [15:0] udp_len;
    logic [15:0] source_port;
    logic [31:0] source_ip;
    logic [15:0] max_len;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] handle_out;
    logic        handle_valid;
    logic [31:0] from_ip;
    logic [15:0] from_port;
    logic [15:0] length_out;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] port;
    logic [15:0] handle;
    logic        pkt_ok;
    logic [15:0] plen;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] max_len;
  } cmd_t;

  function automatic out_t mk_result(logic [2:0] status, logic [15:0] handle,
                                     logic hv, logic [31:0] ip, logic [15:0] port,
                                     logic [15:0] len, logic last);
    out_t r;
    r.status       = status;
    r.handle_out   = handle;
    r.handle_valid = hv;
    r.from_ip      = ip;
    r.from_port    = port;
    r.length_out   = len;
    r.last         = last;
    return r;
  endfunction

endpackage

/* design/udp_port_demux_queues.sv */
// UDP port demultiplexer with a receive queue per bound port. Each input beat is one
// operation: bind, unbind, packet arrival or receive. A command passes through the back
// end in steps (pop, table lookup, execute), with an entry memory read added on a
// receive from a non-empty queue; an unbind repeats the execute and read steps for each
// queued packet it releases. The single-port entry memory and the one result register
// set these steps; a two-entry command queue lets the input accept up to two commands
// while the back end works or is stalled. No clearing pass is needed after reset.
// Depends on udpq_pkg, udpq_front, udpq_cmdq, udpq_back.
module udp_port_demux_queues #(
  parameter int PORT_SLOTS  = udpq_pkg::DEF_PORT_SLOTS,
  parameter int QUEUE_DEPTH = udpq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  udpq_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output udpq_pkg::out_t  out_data
);
  import udpq_pkg::*;

  logic push, q_ready, q_valid, pop;
  cmd_t push_data, q_data;

  udpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .q_ready   (q_ready),
    .cmd       (push_data)
  );

  udpq_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  udpq_back #(
    .PORT_SLOTS  (PORT_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/udpq_front.sv */
// Front end: accepts input beats, holds the own address register, checks packet headers.
// Depends on udpq_pkg; feeds udpq_cmdq.
module udpq_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_wdata,
  input  logic            in_valid,
  output logic            in_ready,
  input  udpq_pkg::in_t   in_data,
  output logic            push,
  input  logic            q_ready,
  output udpq_pkg::cmd_t  cmd
);
  import udpq_pkg::*;

  logic [31:0] own_addr_r;
  logic        hdr_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= 32'h0A00020F;
    end else if (cfg_we) begin
      own_addr_r <= cfg_wdata;
    end
  end

  always_comb begin
    hdr_ok = (in_data.frame_len >= MIN_FRAME_LEN)
          && (in_data.ver_ihl == VER_IHL_IPV4)
          && (in_data.protocol == PROTO_UDP)
          && (in_data.dest_ip == own_addr_r)
          && (in_data.ip_total_len >= MIN_IP_LEN)
          && ((ETH_HDR_LEN + {1'b0, in_data.ip_total_len}) <= {1'b0, in_data.frame_len})
          && (in_data.udp_len >= UDP_HDR_LEN)
          && (({1'b0, in_data.udp_len} + IP_HDR_LEN) <= {1'b0, in_data.ip_total_len});
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  always_comb begin
    cmd.mode      = in_data.mode;
    cmd.port      = in_data.port;
    cmd.handle    = in_data.buffer_handle;
    cmd.pkt_ok    = hdr_ok;
    cmd.plen      = in_data.udp_len - UDP_HDR_LEN;
    cmd.peer_ip   = in_data.source_ip;
    cmd.peer_port = in_data.source_port;
    cmd.max_len   = in_data.max_len;
  end

endmodule

/* design/udpq_cmdq.sv */
// Two-entry command queue between front and back end.
// Depends on udpq_pkg.
module udpq_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  udpq_pkg::cmd_t  push_data,
  output logic            q_ready,
  input  logic            pop,
  output logic            q_valid,
  output udpq_pkg::cmd_t  q_data
);
  import udpq_pkg::*;

  cmd_t       buf_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign q_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = buf_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* design/udpq_back.sv */
// Back end: port table, per-port FIFO pointers, entry memory, result register.
// Depends on udpq_pkg; pops commands from udpq_cmdq.
module udpq_back #(
  parameter int PORT_SLOTS  = udpq_pkg::DEF_PORT_SLOTS,
  parameter int QUEUE_DEPTH = udpq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  udpq_pkg::cmd_t  q_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output udpq_pkg::out_t  out_data
);
  import udpq_pkg::*;

  localparam int SW      = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam int QW      = $clog2(QUEUE_DEPTH);
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = PORT_SLOTS * QUEUE_DEPTH;
  localparam int AW      = $clog2(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_EXEC = 4'b0100,
    S_RD   = 4'b1000
  } state_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] plen;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
  } entry_t;

  state_t      state_r, state_nxt;
  cmd_t        cmd_r;
  logic        hit_r, free_ok_r;
  logic [SW-1:0] slot_r;

  logic          slot_used_r [PORT_SLOTS];
  logic [15:0]   slot_port_r [PORT_SLOTS];
  logic [QW-1:0] head_r      [PORT_SLOTS];
  logic [QW-1:0] tail_r      [PORT_SLOTS];
  logic [CW-1:0] cnt_r       [PORT_SLOTS];

  entry_t      mem [ENTRIES];
  entry_t      rdata_r;

  logic        out_valid_r;
  out_t        out_data_r;

  logic          hit, any_free;
  logic [SW-1:0] hit_idx, free_idx;
  logic          out_free, mem_we, mem_re, emit;
  logic [CW-1:0] cur_cnt;
  logic [QW-1:0] cur_head, cur_tail, head_inc, tail_inc;
  logic [AW-1:0] mem_addr;
  entry_t        mem_wdata;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = 0; i < PORT_SLOTS; i++) begin
      if (!hit && slot_used_r[i] && (slot_port_r[i] == cmd_r.port)) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (!any_free && !slot_used_r[i]) begin
        any_free = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign cur_cnt  = cnt_r[slot_r];
  assign cur_head = head_r[slot_r];
  assign cur_tail = tail_r[slot_r];
  assign head_inc = (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  assign tail_inc = (cur_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : cur_tail + 1'b1;

  assign mem_we = (state_r == S_EXEC) && out_free && (cmd_r.mode == MODE_PKT)
               && cmd_r.pkt_ok && hit_r && (cur_cnt < CW'(QUEUE_DEPTH));
  assign mem_re = (state_r == S_EXEC) && out_free && hit_r && (cur_cnt != '0)
               && ((cmd_r.mode == MODE_UNBIND) || (cmd_r.mode == MODE_RECV));
  assign mem_addr = AW'(slot_r) * AW'(QUEUE_DEPTH)
                  + AW'(mem_we ? cur_tail : cur_head);
  assign emit = ((state_r == S_EXEC) && out_free && !mem_re)
             || ((state_r == S_RD) && out_free);

  always_comb begin
    mem_wdata.handle    = cmd_r.handle;
    mem_wdata.plen      = cmd_r.plen;
    mem_wdata.peer_ip   = cmd_r.peer_ip;
    mem_wdata.peer_port = cmd_r.peer_port;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_addr];
  end

  assign pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = q_valid ? S_LOOK : S_IDLE;
      S_LOOK:  state_nxt = S_EXEC;
      S_EXEC:  state_nxt = !out_free ? S_EXEC : (mem_re ? S_RD : S_IDLE);
      S_RD:    state_nxt = !out_free ? S_RD
                         : ((cmd_r.mode == MODE_UNBIND) ? S_EXEC : S_IDLE);
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= q_data;
    if (state_r == S_LOOK) begin
      hit_r     <= hit;
      free_ok_r <= any_free;
      slot_r    <= hit ? hit_idx : free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PORT_SLOTS; i++) begin
        slot_used_r[i] <= 1'b0;
        slot_port_r[i] <= '0;
        head_r[i]      <= '0;
        tail_r[i]      <= '0;
        cnt_r[i]       <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if ((state_r == S_EXEC) && out_free && !mem_re) begin
        unique case (cmd_r.mode)
          MODE_BIND: begin
            if (hit_r || !free_ok_r) begin
              out_data_r <= mk_result(ST_REJECT, '0, 1'b0, '0, '0, '0, 1'b1);
            end else begin
              slot_used_r[slot_r] <= 1'b1;
              slot_port_r[slot_r] <= cmd_r.port;
              head_r[slot_r]      <= '0;
              tail_r[slot_r]      <= '0;
              cnt_r[slot_r]       <= '0;
              out_data_r <= mk_result(ST_OK, '0, 1'b0, '0, '0, '0, 1'b1);
            end
          end
          MODE_UNBIND: begin
            if (!hit_r) begin
              out_data_r <= mk_result(ST_REJECT, '0, 1'b0, '0, '0, '0, 1'b1);
            end else begin
              slot_used_r[slot_r] <= 1'b0;
              slot_port_r[slot_r] <= '0;
              head_r[slot_r]      <= '0;
              tail_r[slot_r]      <= '0;
              cnt_r[slot_r]       <= '0;
              out_data_r <= mk_result(ST_OK, '0, 1'b0, '0, '0, '0, 1'b1);
            end
          end
          MODE_PKT: begin
            if (mem_we) begin
              tail_r[slot_r] <= tail_inc;
              cnt_r[slot_r]  <= cur_cnt + 1'b1;
              out_data_r <= mk_result(ST_OK, '0, 1'b0, '0, '0, '0, 1'b1);
            end else begin
              out_data_r <= mk_result(ST_DROP, cmd_r.handle, 1'b1, '0, '0, '0, 1'b1);
            end
          end
          MODE_RECV: begin
            if (!hit_r) begin
              out_data_r <= mk_result(ST_REJECT, '0, 1'b0, '0, '0, '0, 1'b1);
            end else begin
              out_data_r <= mk_result(ST_EMPTY, '0, 1'b0, '0, '0, '0, 1'b1);
            end
          end
          default: out_data_r <= mk_result(ST_REJECT, '0, 1'b0, '0, '0, '0, 1'b1);
        endcase
      end
      if (mem_re) begin
        head_r[slot_r] <= head_inc;
        cnt_r[slot_r]  <= cur_cnt - 1'b1;
      end
      if ((state_r == S_RD) && out_free) begin
        if (cmd_r.mode == MODE_UNBIND) begin
          out_data_r <= mk_result(ST_RELEASE, rdata_r.handle, 1'b1, '0, '0, '0, 1'b0);
        end else begin
          out_data_r <= mk_result(ST_OK, rdata_r.handle, 1'b1, rdata_r.peer_ip,
                                  rdata_r.peer_port,
                                  (rdata_r.plen < cmd_r.max_len) ? rdata_r.plen
                                                                 : cmd_r.max_len,
                                  1'b1);
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_rd_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_RD))
    else $error("read stage entered without a memory read");

  a_hit_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && hit_r) |-> slot_used_r[slot_r])
    else $error("matched slot is not bound");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> (cur_cnt <= CW'(QUEUE_DEPTH)))
    else $error("queue count exceeds depth");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == S_LOOK))
    else $error("popped command not looked up");

endmodule
